// ===== rtl/evh_pkg.sv =====
// Shared types, constants and hash functions for the event name identity hash.
// Used by evh_front, evh_queue, evh_back and event_name_identity_hash.
// No dependencies.
package evh_pkg;

	// Longest accepted name, in characters (exclusive bound).
	localparam int NAME_LIMIT = 256;
	// Character counters saturate at NAME_LIMIT, so they must be able to hold it.
	localparam int CNT_W = $clog2(NAME_LIMIT + 1);
	localparam int PREFIX_LEN = 5;

	localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
	localparam logic [31:0] FNV_PRIME = 32'h01000193;

	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5a;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	// Queue between the classifier and the hash engine; depth is a power of two.
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} evh_in_t;

	typedef struct packed {
		logic        valid_res;
		logic [31:0] identity;
	} evh_out_t;

	// Which running hash becomes the identity at the end of a name.
	typedef enum logic [1:0] {
		PICK_WHOLE   = 2'd0,
		PICK_SEGMENT = 2'd1,
		PICK_STEM    = 2'd2
	} evh_pick_t;

	// One classified character, as handed from the front end to the hash engine.
	typedef struct packed {
		logic [7:0] folded;     // character with upper case folded to lower
		logic       sep;        // either slash: restart segment and stem
		logic       dot;        // extension start: stem takes the segment hash
		logic       last;       // final character of the name
		logic       accept_ok;  // name passes length and ASCII checks (last only)
		evh_pick_t  pick;       // hash to report (last only)
	} evh_op_t;

	function automatic logic [7:0] fold(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

	// One FNV-1 step on an already folded byte.
	function automatic logic [31:0] mix(input logic [31:0] h, input logic [7:0] f);
		logic [31:0] p;
		p = h * FNV_PRIME;
		return p ^ {24'h000000, f};
	endfunction

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] r;
		r = n;
		if (n < CNT_W'(NAME_LIMIT)) begin
			r = n + 1'b1;
		end
		return r;
	endfunction

	function automatic logic [7:0] play_tag(input logic [2:0] idx);
		logic [7:0] r;
		unique case (idx)
			3'd0: r = "p";
			3'd1: r = "l";
			3'd2: r = "a";
			3'd3: r = "y";
			3'd4: r = "_";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] stop_tag(input logic [2:0] idx);
		logic [7:0] r;
		unique case (idx)
			3'd0: r = "s";
			3'd1: r = "t";
			3'd2: r = "o";
			3'd3: r = "p";
			3'd4: r = "_";
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] play_seed();
		logic [31:0] h;
		h = FNV_BASIS;
		for (int i = 0; i < PREFIX_LEN; i++) begin
			h = mix(h, play_tag(3'(i)));
		end
		return h;
	endfunction

	// Hash of "play_" from the basis; start value of segment and stem hashes.
	localparam logic [31:0] PLAY_SEED = play_seed();

endpackage

// ===== rtl/evh_front.sv =====
// Front end of the event name hash: accepts characters and classifies them.
// Tracks counts, prefix match and path flags; decides the verdict at the last character.
// Depends on evh_pkg.
module evh_front import evh_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  evh_in_t in_item,
	input  logic    q_ready,
	output logic    push,
	output evh_op_t op
);

	logic [CNT_W-1:0] name_cnt_q, seg_cnt_q, stem_cnt_q;
	logic             dot_q, ascii_q, fslash_q, pplay_q, pstop_q;

	logic [CNT_W-1:0] name_n, seg_n, stem_n, keep_cnt;
	logic             dot_n, ascii_n, fslash_n, pplay_n, pstop_n;
	logic [7:0]       c, f;
	logic             sep, dot, rule_one, too_long;

	assign push = in_valid && q_ready;

	always_comb begin
		c = in_item.character;
		f = fold(c);
		sep = (c == CH_SLASH) || (c == CH_BSLASH);
		dot = !sep && (c == CH_DOT);

		name_n   = bump(name_cnt_q);
		ascii_n  = ascii_q && !c[7];
		fslash_n = fslash_q || (c == CH_SLASH);
		pplay_n  = pplay_q;
		pstop_n  = pstop_q;
		if (name_cnt_q < CNT_W'(PREFIX_LEN)) begin
			if (f != play_tag(name_cnt_q[2:0])) pplay_n = 1'b0;
			if (f != stop_tag(name_cnt_q[2:0])) pstop_n = 1'b0;
		end

		if (sep) begin
			seg_n  = '0;
			stem_n = '0;
			dot_n  = 1'b0;
		end else begin
			seg_n  = bump(seg_cnt_q);
			stem_n = dot ? seg_cnt_q : stem_cnt_q;
			dot_n  = dot_q || dot;
		end

		rule_one = (name_n >= CNT_W'(PREFIX_LEN)) && (pplay_n || pstop_n) && !fslash_n;
		keep_cnt = dot_n ? stem_n : seg_n;
		too_long = ({1'b0, keep_cnt} + (CNT_W + 1)'(PREFIX_LEN)) >= (CNT_W + 1)'(NAME_LIMIT);

		op.folded    = f;
		op.sep       = sep;
		op.dot       = dot;
		op.last      = in_item.last;
		op.accept_ok = ascii_n && (name_n < CNT_W'(NAME_LIMIT)) && (rule_one || !too_long);
		if (rule_one) begin
			op.pick = PICK_WHOLE;
		end else if (dot_n) begin
			op.pick = PICK_STEM;
		end else begin
			op.pick = PICK_SEGMENT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_cnt_q <= '0;
			seg_cnt_q  <= '0;
			stem_cnt_q <= '0;
			dot_q      <= 1'b0;
			ascii_q    <= 1'b1;
			fslash_q   <= 1'b0;
			pplay_q    <= 1'b1;
			pstop_q    <= 1'b1;
		end else if (push) begin
			if (in_item.last) begin
				name_cnt_q <= '0;
				seg_cnt_q  <= '0;
				stem_cnt_q <= '0;
				dot_q      <= 1'b0;
				ascii_q    <= 1'b1;
				fslash_q   <= 1'b0;
				pplay_q    <= 1'b1;
				pstop_q    <= 1'b1;
			end else begin
				name_cnt_q <= name_n;
				seg_cnt_q  <= seg_n;
				stem_cnt_q <= stem_n;
				dot_q      <= dot_n;
				ascii_q    <= ascii_n;
				fslash_q   <= fslash_n;
				pplay_q    <= pplay_n;
				pstop_q    <= pstop_n;
			end
		end
	end

endmodule

// ===== rtl/evh_queue.sv =====
// Short queue of classified characters between the front end and the hash engine.
// Lets either side stall without stopping the other until the queue fills or runs empty.
// Depends on evh_pkg.
module evh_queue import evh_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  evh_op_t push_op,
	output logic    ready,
	output logic    q_valid,
	output evh_op_t q_op,
	input  logic    pop
);

	evh_op_t            entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign ready   = (cnt_q != Q_CNT_W'(Q_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_op    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/evh_back.sv =====
// Hash engine of the event name hash: runs the whole, segment and stem FNV-1 hashes.
// Picks the identity at the last character and holds it in the output register.
// Depends on evh_pkg.
module evh_back import evh_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_valid,
	input  evh_op_t  q_op,
	output logic     pop,
	output logic     id_valid,
	output evh_out_t id_item,
	input  logic     id_stall
);

	logic [31:0] whole_q, seg_q, stem_q;
	logic [31:0] whole_n, seg_n, stem_n, id_sel;
	logic        res_valid_q, out_free, id_ok;
	evh_out_t    res_q;

	assign out_free = !res_valid_q || !id_stall;
	assign pop      = q_valid && (!q_op.last || out_free);
	assign id_valid = res_valid_q;
	assign id_item  = res_q;

	always_comb begin
		whole_n = mix(whole_q, q_op.folded);
		if (q_op.sep) begin
			seg_n  = PLAY_SEED;
			stem_n = PLAY_SEED;
		end else begin
			seg_n  = mix(seg_q, q_op.folded);
			stem_n = q_op.dot ? seg_q : stem_q;
		end
		unique case (q_op.pick)
			PICK_WHOLE:   id_sel = whole_n;
			PICK_SEGMENT: id_sel = seg_n;
			PICK_STEM:    id_sel = stem_n;
			default:      id_sel = '0;
		endcase
		id_ok = q_op.accept_ok && (id_sel != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			whole_q <= FNV_BASIS;
			seg_q   <= PLAY_SEED;
			stem_q  <= PLAY_SEED;
		end else if (pop) begin
			if (q_op.last) begin
				whole_q <= FNV_BASIS;
				seg_q   <= PLAY_SEED;
				stem_q  <= PLAY_SEED;
			end else begin
				whole_q <= whole_n;
				seg_q   <= seg_n;
				stem_q  <= stem_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop && q_op.last) begin
			res_valid_q <= 1'b1;
		end else if (!id_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && q_op.last) begin
			res_q.valid_res <= id_ok;
			res_q.identity  <= id_ok ? id_sel : 32'h00000000;
		end
	end

	a_refused_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		id_valid && !id_item.valid_res |-> id_item.identity == 32'h00000000)
		else $error("refused name carries a nonzero identity");

	a_accepted_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		id_valid && id_item.valid_res |-> id_item.identity != 32'h00000000)
		else $error("accepted name carries a zero identity");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && id_stall |-> !(pop && q_op.last))
		else $error("held result overwritten by a new name");

endmodule

// ===== rtl/event_name_identity_hash.sv =====
// Top level of the event name identity hash: front end, queue and hash engine.
// Depends on evh_pkg, evh_front, evh_queue and evh_back.
//
// The block takes an event declaration one character per transfer on the name channel,
// the final character flagged by last, and returns one result transfer per name on the
// id channel: a 32-bit case-insensitive FNV-1 identity and a valid_res flag. Names of
// NAME_LIMIT characters or more, or holding any byte of 128 or above, are refused. If
// the name starts with "play_" or "stop_" (any case) and contains no forward slash the
// whole name is hashed; otherwise the identity is the hash of "play_" followed by the
// last path segment (forward slash or backslash separates segments) without its final
// extension, and that form is refused when its length would reach NAME_LIMIT. A refused
// name, or one whose hash is zero, reports valid_res = 0 and identity = 0. The block
// takes one character per cycle while the queue has room; the rate is set by the hash
// engine, which performs one constant multiply and xor per running hash each cycle. Each
// character is written into the queue at its transfer and taken out by the hash engine,
// and the result of a name is registered in the output register when its last character
// is taken out, which waits while an earlier result is still waiting to be taken. The front end
// keeps accepting characters while a finished result waits to be taken, until its
// two-entry queue fills. There is no clearing pass after reset and no configuration.
module event_name_identity_hash import evh_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     name_valid,
	output logic     name_stall,
	input  evh_in_t  name_item,
	output logic     id_valid,
	input  logic     id_stall,
	output evh_out_t id_item
);

	logic    push, q_ready, q_valid, pop;
	evh_op_t push_op, q_op;

	// The front end can take a character whenever the queue has room.
	assign name_stall = !q_ready;

	evh_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(name_valid),
		.in_item (name_item),
		.q_ready (q_ready),
		.push    (push),
		.op      (push_op)
	);

	evh_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.push_op(push_op),
		.ready  (q_ready),
		.q_valid(q_valid),
		.q_op   (q_op),
		.pop    (pop)
	);

	evh_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_op    (q_op),
		.pop     (pop),
		.id_valid(id_valid),
		.id_item (id_item),
		.id_stall(id_stall)
	);

endmodule

// ===== sim/tb_top.sv =====
// Testbench for event_name_identity_hash: a table of directed names, then random names.
// Results are checked against a predictor of the case-insensitive FNV-1 identity.
// Depends on evh_pkg and the RTL of event_name_identity_hash.
`timescale 1ns / 1ps

module tb_top;
	import evh_pkg::*;

	// Characters of random names to send after the directed table.
	localparam int RANDOM_CHARS = 400;
	// The limit leaves a wide margin over the slowest correct run.
	localparam int CYCLE_LIMIT = 1_000_000;
	// Extra cycles to wait at the end, after the last expected result.
	localparam int DRAIN_CYCLES = 8;
	localparam evh_out_t REFUSED = '0;

	// One directed name: the text, then pad_len copies of pad_ch. Where typed is set,
	// the expected result is the one given in the row rather than the predicted one.
	typedef struct {
		string      text;
		int         pad_len;
		logic [7:0] pad_ch;
		bit         typed;
		evh_out_t   want;
	} name_case_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     name_valid = 1'b0;
	logic     name_stall;
	evh_in_t  name_item = '0;
	logic     id_valid;
	logic     id_stall = 1'b0;
	evh_out_t id_item;

	event_name_identity_hash u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.name_valid (name_valid),
		.name_stall (name_stall),
		.name_item  (name_item),
		.id_valid   (id_valid),
		.id_stall   (id_stall),
		.id_item    (id_item)
	);

	always #1 clk = ~clk;

	// Predictor state: one running hash over the whole name, one over "play_" plus the
	// current path segment, and one frozen at the last dot of that segment.
	logic [31:0]      full_h;
	logic [31:0]      seg_h;
	logic [31:0]      stem_h;
	logic [31:0]      play_start;
	logic [CNT_W-1:0] n_all;
	logic [CNT_W-1:0] n_seg;
	logic [CNT_W-1:0] n_stem;
	bit               has_ext;
	bit               ascii_ok;
	bit               fwd_seen;
	bit               like_play;
	bit               like_stop;

	string play_word = "play_";
	string stop_word = "stop_";
	// Characters for well-formed random names: case edges, a backslash separator and a dot.
	string word_set = "aAzZmM09_-@[`{.~\\";

	evh_out_t   id_expected[$];
	logic [7:0] name_buf[$];
	int         mismatch_count = 0;
	int         cycle_count = 0;

	// The directed table: prefix rules, path handling, byte extremes and length limits.
	name_case_t dir_cases[22] = '{
		'{"play_Jump", 0, 8'h00, 1'b0, REFUSED},
		'{"STOP_All", 0, 8'h00, 1'b0, REFUSED},
		'{"stop_", 0, 8'h00, 1'b0, REFUSED},           // exactly the prefix
		'{"play", 0, 8'h00, 1'b0, REFUSED},            // too short for the whole-name rule
		'{"x", 0, 8'h00, 1'b0, REFUSED},
		'{"Play_x/y.wav", 0, 8'h00, 1'b0, REFUSED},    // forward slash forces the path rule
		'{"play_a\\b.c", 0, 8'h00, 1'b0, REFUSED},     // backslash keeps the whole name
		'{"Sfx\\Door.Open.ogg", 0, 8'h00, 1'b0, REFUSED},
		'{"sounds/.hidden", 0, 8'h00, 1'b0, REFUSED},  // empty stem
		'{"dir/", 0, 8'h00, 1'b0, REFUSED},            // empty final segment
		'{"plaY-x", 0, 8'h00, 1'b0, REFUSED},
		'{"AZ@[`az{", 0, 8'h00, 1'b0, REFUSED},        // edges of the case fold
		'{"", 3, 8'h01, 1'b0, REFUSED},
		'{"ab", 1, 8'h00, 1'b0, REFUSED},              // zero byte hashes as any other
		'{"q", 2, 8'h7f, 1'b0, REFUSED},
		'{"play_", 1, 8'h80, 1'b1, REFUSED},
		'{"ab", 1, 8'hff, 1'b1, REFUSED},
		'{"play_", 250, "a", 1'b0, REFUSED},           // longest accepted name
		'{"play_", 251, "a", 1'b1, REFUSED},           // one character too long
		'{"stop_", 255, "b", 1'b1, REFUSED},           // counters saturate
		'{"", 250, "q", 1'b0, REFUSED},                // longest accepted stem
		'{"a/", 251, "b", 1'b1, REFUSED}               // short name, stem too long
	};

	function automatic logic [7:0] lower_ch(input logic [7:0] c);
		return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_OFFSET : c;
	endfunction

	function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] c);
		logic [31:0] p;
		p = h * FNV_PRIME;
		return p ^ {24'h000000, lower_ch(c)};
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] n);
		return (n < CNT_W'(NAME_LIMIT)) ? n + 1'b1 : n;
	endfunction

	function automatic void reset_hash_state();
		play_start = FNV_BASIS;
		for (int i = 0; i < PREFIX_LEN; i++) begin
			play_start = fnv_step(play_start, play_word[i]);
		end
		full_h = FNV_BASIS;
		seg_h = play_start;
		stem_h = play_start;
		n_all = '0;
		n_seg = '0;
		n_stem = '0;
		has_ext = 1'b0;
		ascii_ok = 1'b1;
		fwd_seen = 1'b0;
		like_play = 1'b1;
		like_stop = 1'b1;
	endfunction

	// Advances the predictor by one transferred character. On the last character it
	// returns 1 with the identity of the whole name and clears the state for the next.
	function automatic bit predict_char(input logic [7:0] c, input bit last,
			output evh_out_t res);
		bit          ok;
		bit          whole;
		int          keep;
		logic [31:0] id;
		if (c >= 8'd128) begin
			ascii_ok = 1'b0;
		end
		if (n_all < PREFIX_LEN) begin
			if (lower_ch(c) != play_word[n_all]) begin
				like_play = 1'b0;
			end
			if (lower_ch(c) != stop_word[n_all]) begin
				like_stop = 1'b0;
			end
		end
		if (c == CH_SLASH) begin
			fwd_seen = 1'b1;
		end
		full_h = fnv_step(full_h, c);
		n_all = sat_inc(n_all);
		if (c == CH_SLASH || c == CH_BSLASH) begin
			seg_h = play_start;
			stem_h = play_start;
			n_seg = '0;
			n_stem = '0;
			has_ext = 1'b0;
		end else begin
			// A dot freezes the stem at the segment so far; a later dot moves it on.
			if (c == CH_DOT) begin
				stem_h = seg_h;
				n_stem = n_seg;
				has_ext = 1'b1;
			end
			seg_h = fnv_step(seg_h, c);
			n_seg = sat_inc(n_seg);
		end
		res = '0;
		if (!last) begin
			return 1'b0;
		end
		ok = ascii_ok && n_all < NAME_LIMIT;
		id = '0;
		if (ok) begin
			whole = n_all >= PREFIX_LEN && (like_play || like_stop) && !fwd_seen;
			if (whole) begin
				id = full_h;
			end else begin
				// "play_" is counted against the limit along with the stem.
				keep = has_ext ? int'(n_stem) : int'(n_seg);
				if (keep + PREFIX_LEN >= NAME_LIMIT) begin
					ok = 1'b0;
				end else begin
					id = has_ext ? stem_h : seg_h;
				end
			end
		end
		ok = ok && id != '0;
		res.valid_res = ok;
		res.identity = ok ? id : '0;
		reset_hash_state();
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic check_identity(input evh_out_t got);
		evh_out_t want;
		if (id_expected.size() == 0) begin
			report_mismatch($sformatf("result valid_res=%0b identity=%08h with no name pending",
				got.valid_res, got.identity));
		end else begin
			want = id_expected.pop_front();
			if (got.valid_res !== want.valid_res) begin
				report_mismatch($sformatf("valid_res %0b, expected %0b",
					got.valid_res, want.valid_res));
			end
			if (got.identity !== want.identity) begin
				report_mismatch($sformatf("identity %08h, expected %08h",
					got.identity, want.identity));
			end
		end
	endtask

	// Presents one character and holds it until a transfer. Called at a rising edge,
	// returns at the edge of the transfer. The stall is sampled at the falling edge
	// before, so the decision never depends on the order of events at the rising edge.
	task automatic send_char(input logic [7:0] c, input bit last, input bit quiet,
			input bit typed, input evh_out_t want);
		int       gap;
		bit       taken;
		evh_out_t res;
		gap = quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			name_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		name_valid <= 1'b1;
		name_item <= '{character: c, last: last};
		do begin
			@(negedge clk);
			taken = !name_stall;
			@(posedge clk);
		end while (!taken);
		if (predict_char(c, last, res)) begin
			id_expected.push_back(typed ? want : res);
		end
	endtask

	// Sends the name held in name_buf; about one name in four goes without gaps.
	task automatic send_name(input bit typed, input evh_out_t want);
		bit quiet;
		quiet = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < name_buf.size(); i++) begin
			send_char(name_buf[i], i == name_buf.size() - 1, quiet, typed, want);
		end
	endtask

	function automatic logic [7:0] word_char();
		if ($urandom_range(0, 15) == 0) begin
			return 8'($urandom_range(1, 255));
		end
		return word_set[$urandom_range(0, word_set.len() - 1)];
	endfunction

	// Fills name_buf with one random name. Most names are well formed: a play_ or
	// stop_ prefix in mixed case, or a path with extensions. The rest are random bytes,
	// and a few are near the length limit.
	task automatic build_random_name();
		int         kind;
		int         len;
		int         segs;
		logic [7:0] ch;
		string      pick;
		name_buf.delete();
		kind = $urandom_range(0, 99);
		if (kind < 35) begin
			pick = $urandom_range(0, 1) ? play_word : stop_word;
			for (int j = 0; j < PREFIX_LEN; j++) begin
				ch = pick[j];
				if (ch != "_" && $urandom_range(0, 1)) begin
					ch = ch - CASE_OFFSET;
				end
				name_buf.push_back(ch);
			end
			// Now and then one prefix character is spoiled.
			if ($urandom_range(0, 9) == 0) begin
				name_buf[$urandom_range(0, PREFIX_LEN - 1)] = word_char();
			end
			len = $urandom_range(0, 12);
			repeat (len) begin
				if ($urandom_range(0, 11) == 0) begin
					name_buf.push_back($urandom_range(0, 1) ? CH_SLASH : CH_BSLASH);
				end else begin
					name_buf.push_back(word_char());
				end
			end
		end else if (kind < 75) begin
			segs = $urandom_range(1, 3);
			for (int s = 0; s < segs; s++) begin
				if (s > 0) begin
					name_buf.push_back($urandom_range(0, 1) ? CH_SLASH : CH_BSLASH);
				end
				repeat ($urandom_range(0, 6)) name_buf.push_back(word_char());
				if ($urandom_range(0, 2) != 0) begin
					name_buf.push_back(CH_DOT);
					repeat ($urandom_range(0, 3)) name_buf.push_back(word_char());
				end
			end
			if (name_buf.size() == 0) begin
				name_buf.push_back(word_char());
			end
		end else if (kind < 97) begin
			repeat ($urandom_range(1, 12)) name_buf.push_back(8'($urandom_range(1, 255)));
		end else begin
			// Long names straddle both length limits.
			len = $urandom_range(245, 262);
			if ($urandom_range(0, 1)) begin
				for (int j = 0; j < PREFIX_LEN; j++) begin
					name_buf.push_back(play_word[j]);
				end
			end
			while (name_buf.size() < len) begin
				name_buf.push_back(8'("a" + $urandom_range(0, 25)));
			end
			if ($urandom_range(0, 1)) begin
				name_buf[len - 2] = CH_DOT;
			end
		end
	endtask

	// Result side: stalls a random number of cycles before each transfer, with runs of
	// no stalling, and checks every transfer against the oldest expected identity.
	initial begin
		bit       fast;
		bit       got;
		int       n;
		evh_out_t seen;
		fast = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			n = fast ? 0 : $urandom_range(0, 14);
			if ($urandom_range(0, 15) == 0) begin
				fast = !fast;
			end
			if (n > 0) begin
				id_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			id_stall <= 1'b0;
			do begin
				@(negedge clk);
				got = id_valid;
				seen = id_item;
				@(posedge clk);
			end while (!got);
			check_identity(seen);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Name side: reset, the directed table, then random names until enough characters
	// have gone in. At the end, wait for every expected identity, then DRAIN_CYCLES more.
	initial begin
		int sent_chars;
		reset_hash_state();
		sent_chars = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_cases[k]) begin
			name_buf.delete();
			for (int j = 0; j < dir_cases[k].text.len(); j++) begin
				name_buf.push_back(dir_cases[k].text[j]);
			end
			repeat (dir_cases[k].pad_len) name_buf.push_back(dir_cases[k].pad_ch);
			send_name(dir_cases[k].typed, dir_cases[k].want);
		end
		while (sent_chars < RANDOM_CHARS) begin
			build_random_name();
			sent_chars += name_buf.size();
			send_name(1'b0, REFUSED);
		end
		name_valid <= 1'b0;
		while (id_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
